// ----- rtl/sli_pkg.sv -----
// sli_pkg: shared types and codes for the segmented list intersection block.
// No dependencies; imported by sli_cell and segmented_list_intersection.
`default_nettype none

package sli_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned TOTAL_W = 32;

  // request codes carried in req_type
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PROBE = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] value;
  } sli_req_t;

  typedef struct packed {
    logic                      is_boundary;
    logic signed [VALUE_W-1:0] match_value;
    logic [TOTAL_W-1:0]        match_total;
    logic                      overflow;
  } sli_rsp_t;

  // per-cycle controls broadcast along the cell row
  typedef struct packed {
    logic shift;   // load word: every cell takes its left neighbor's value
    logic probe;   // probe word: every cell compares and registers a hit
  } sli_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sli_cell.sv -----
// sli_cell: one storage cell of the row; holds one second-list element.
// Depends on sli_pkg.
`default_nettype none

module sli_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sli_pkg::sli_cell_ctrl_t        ctrl,
  input  wire logic                           live,      // cell lies below fill count
  input  wire logic [sli_pkg::VALUE_W-1:0]    shift_in,  // from left neighbor
  input  wire logic [sli_pkg::VALUE_W-1:0]    probe_value,
  output logic      [sli_pkg::VALUE_W-1:0]    shift_out, // to right neighbor
  output logic                                hit
);
  import sli_pkg::*;

  logic [VALUE_W-1:0] elem;

  // element register, no reset: only read once live
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      elem <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= ctrl.probe & live & (elem == probe_value);
    end
  end

  assign shift_out = elem;

endmodule

`default_nettype wire

// ----- rtl/segmented_list_intersection.sv -----
// segmented_list_intersection: top level, row of sli_cell storage cells
// plus fill count, running total and overflow tracking. Depends on sli_pkg, sli_cell.
`default_nettype none

//  channel  | ports                 | handshake
//  ---------+-----------------------+---------------------------------------
//  request  | start, busy, req      | word taken at edge with start & !busy
//  result   | done, rsp             | word valid for the one cycle done is high
//
// A load or an end-of-segment word never raises busy. A probe runs in steps:
// every cell compares the probe against its element and registers a hit flag,
// then the hit flags are OR-ed and the running total is updated; busy is high
// while the flags are gathered. The result of an end word shows in the cycle
// after it is taken; a match result is registered after the gather step.
// Reset (rst, synchronous) empties the fill count, total and overflow flag.
// The receiver cannot stall: each result is shown for exactly one cycle.

module segmented_list_intersection #(
  parameter int unsigned MAX_LIST = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire sli_pkg::sli_req_t req,
  output logic                   done,
  output sli_pkg::sli_rsp_t      rsp
);
  import sli_pkg::*;

  localparam int unsigned FILL_W = $clog2(MAX_LIST + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_LIST);

  // control state
  logic [FILL_W-1:0]  fill_count;
  logic [FILL_W-1:0]  fill_count_next;
  logic [TOTAL_W-1:0] running_total;
  logic [TOTAL_W-1:0] running_total_next;
  logic               overflow_flag;
  logic               overflow_flag_next;
  logic               pend;              // probe compares are in the cells
  logic               pend_next;
  logic               done_next;

  // payload
  logic [VALUE_W-1:0] pend_value;
  sli_rsp_t           rsp_next;

  logic               accept;
  logic               hit_any;
  sli_cell_ctrl_t     ctrl;

  logic [VALUE_W-1:0] chain [MAX_LIST+1];  // chain[i] feeds cell i
  logic [MAX_LIST-1:0] hits;

  assign accept = start & ~busy;
  assign busy   = pend;

  // new loads enter at cell 0 and push older elements to the right, so the
  // live elements always sit in cells 0 .. fill_count-1
  always_comb begin
    ctrl.shift = accept && (req.req_type == REQ_LOAD) && (fill_count < FILL_MAX);
    ctrl.probe = accept && (req.req_type == REQ_PROBE);
  end

  assign chain[0] = req.value;

  for (genvar i = 0; i < MAX_LIST; i++) begin : g_cell
    localparam logic [FILL_W-1:0] IDX = FILL_W'(i);
    sli_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .live        (IDX < fill_count),
      .shift_in    (chain[i]),
      .probe_value (req.value),
      .shift_out   (chain[i+1]),
      .hit         (hits[i])
    );
  end

  assign hit_any = |hits;

  always_comb begin
    fill_count_next    = fill_count;
    running_total_next = running_total;
    overflow_flag_next = overflow_flag;
    pend_next          = 1'b0;
    done_next          = 1'b0;
    rsp_next           = '0;

    if (pend) begin
      // gather step of a probe: collect cell hits
      if (hit_any) begin
        if (running_total != TOTAL_MAX) begin
          running_total_next = running_total + TOTAL_W'(1);
        end
        done_next            = 1'b1;
        rsp_next.is_boundary = 1'b0;
        rsp_next.match_value = pend_value;
        rsp_next.match_total = running_total_next;
        rsp_next.overflow    = overflow_flag;
      end
    end else if (accept) begin
      unique case (req.req_type)
        REQ_LOAD: begin
          if (fill_count < FILL_MAX) begin
            fill_count_next = fill_count + FILL_W'(1);
          end else begin
            overflow_flag_next = 1'b1;
          end
        end
        REQ_PROBE: begin
          pend_next = 1'b1;
        end
        REQ_END: begin
          done_next            = 1'b1;
          rsp_next.is_boundary = 1'b1;
          rsp_next.match_value = '0;
          rsp_next.match_total = running_total;
          rsp_next.overflow    = overflow_flag;
          fill_count_next      = '0;
          overflow_flag_next   = 1'b0;
        end
        default: begin
          // unused code: no result, no state change
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      running_total <= '0;
      overflow_flag <= 1'b0;
      pend          <= 1'b0;
      done          <= 1'b0;
    end else begin
      fill_count    <= fill_count_next;
      running_total <= running_total_next;
      overflow_flag <= overflow_flag_next;
      pend          <= pend_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.probe) begin
      pend_value <= req.value;
    end
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

// ----- tb/sv/sli_intersection_checker.sv -----
// sli_intersection_checker: watches the request and result channels of
// segmented_list_intersection, predicts every result word and compares it.
// Depends on sli_pkg.
`timescale 1ns / 100ps

module sli_intersection_checker #(
  parameter int unsigned MAX_LIST = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire sli_pkg::sli_req_t req,
  input  wire logic              done,
  input  wire sli_pkg::sli_rsp_t rsp,
  output int                     mismatches,
  output int                     pending
);
  import sli_pkg::*;

  // predicted state of the block
  logic [VALUE_W-1:0] held_values [MAX_LIST];
  int unsigned        held_count;
  logic [TOTAL_W-1:0] match_count;
  logic               dropped_load;

  sli_rsp_t expected_words [$];

  task automatic predict_intersection(input sli_req_t word);
    sli_rsp_t r;
    bit       hit;
    hit = 0;
    case (word.req_type)
      REQ_LOAD: begin
        if (held_count < MAX_LIST) begin
          held_values[held_count] = word.value;
          held_count++;
        end else begin
          dropped_load = 1'b1;
        end
      end
      REQ_PROBE: begin
        for (int i = 0; i < held_count; i++)
          if (held_values[i] == word.value) hit = 1;
        if (hit) begin
          if (match_count != TOTAL_MAX) match_count++;
          r.is_boundary = 1'b0;
          r.match_value = word.value;
          r.match_total = match_count;
          r.overflow    = dropped_load;
          expected_words.push_back(r);
        end
      end
      REQ_END: begin
        r.is_boundary = 1'b1;
        r.match_value = '0;
        r.match_total = match_count;
        r.overflow    = dropped_load;
        expected_words.push_back(r);
        held_count   = 0;
        dropped_load = 1'b0;
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  always @(posedge clk) begin
    sli_rsp_t want;
    if (rst) begin
      held_count   = 0;
      match_count  = '0;
      dropped_load = 1'b0;
      expected_words.delete();
      mismatches   = 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, rsp);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (rsp.is_boundary !== want.is_boundary) begin
            $display("%0t: is_boundary expected %0b actual %0b",
                     $time, want.is_boundary, rsp.is_boundary);
            mismatches++;
          end
          if (rsp.match_value !== want.match_value) begin
            $display("%0t: match_value expected %h actual %h",
                     $time, want.match_value, rsp.match_value);
            mismatches++;
          end
          if (rsp.match_total !== want.match_total) begin
            $display("%0t: match_total expected %0d actual %0d",
                     $time, want.match_total, rsp.match_total);
            mismatches++;
          end
          if (rsp.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b",
                     $time, want.overflow, rsp.overflow);
            mismatches++;
          end
        end
      end
      if (start && !busy) predict_intersection(req);
    end
    pending = expected_words.size();
  end

endmodule

// ----- tb/sv/tb_segmented_list_intersection.sv -----
// tb_segmented_list_intersection: drives segments of load, probe and end
// words into segmented_list_intersection and gives the verdict.
// Depends on sli_pkg, the block and sli_intersection_checker.
`timescale 1ns / 100ps

module tb_segmented_list_intersection;
  import sli_pkg::*;

  localparam int unsigned MAX_LIST   = 64;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;   // code the block ignores
  localparam int          RANDOM_WORDS = 750;
  localparam int          STALL_LIMIT  = 2000; // idle cycles before giving up
  localparam int          DRAIN_CYCLES = 8;    // extra wait after the checker queue empties

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  sli_req_t req;
  logic     done;
  sli_rsp_t rsp;

  int mismatches;
  int pending;
  int idle_cycles;

  // words sent that the block acts on; unused-code noise is not counted
  int  words_sent;
  // no gaps while set, so back-to-back words are exercised too
  bit  burst;
  // values loaded in the current segment, used to aim probes at hits
  logic [VALUE_W-1:0] segment_values [$];
  logic [VALUE_W-1:0] value_pool [6];

  segmented_list_intersection #(.MAX_LIST(MAX_LIST)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  sli_intersection_checker #(.MAX_LIST(MAX_LIST)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("segmented_list_intersection verification failed");
        $finish;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] any_value();
    return {$urandom, $urandom};
  endfunction

  // Present one request word after a random gap and hold it until taken.
  // Called right after an edge; start is touched at most once per step.
  task automatic send_word(input logic [1:0] kind, input logic [VALUE_W-1:0] v);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    req.req_type <= kind;
    req.value    <= v;
    do @(posedge clk); while (busy);
    if (kind != REQ_UNUSED) words_sent++;
    if (kind == REQ_LOAD) segment_values.push_back(v);
    if (kind == REQ_END) segment_values.delete();
  endtask

  function automatic logic [VALUE_W-1:0] pick_load_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return value_pool[$urandom_range(0, 5)];
      3:       return {1'b1, {(VALUE_W-1){1'b0}}};
      default: return any_value();
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_probe_value();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12 && segment_values.size() > 0)
      return segment_values[$urandom_range(0, segment_values.size() - 1)];
    else if (roll < 17)
      return value_pool[$urandom_range(0, 5)];
    else
      return any_value();
  endfunction

  // One segment: loads, then probes with the odd late load or noise word,
  // then usually an end word. A missing end lets a segment run on.
  task automatic run_segment();
    int n_loads;
    int n_probes;
    int roll;
    burst = ($urandom_range(0, 3) == 0);
    foreach (value_pool[i]) value_pool[i] = any_value();
    // every eighth segment or so loads up to 72 values and may overrun the store, setting the overflow flag
    n_loads  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72)
                                           : $urandom_range(0, 10);
    n_probes = $urandom_range(0, 12);
    repeat (n_loads) send_word(REQ_LOAD, pick_load_value());
    repeat (n_probes) begin
      roll = $urandom_range(0, 19);
      if (roll < 2)       send_word(REQ_LOAD, pick_load_value());
      else if (roll == 2) send_word(REQ_UNUSED, any_value());
      else                send_word(REQ_PROBE, pick_probe_value());
    end
    if ($urandom_range(0, 11) != 0) send_word(REQ_END, any_value());
  endtask

  localparam logic [VALUE_W-1:0] VAL_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VAL_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_ZERO = '0;
  localparam logic [VALUE_W-1:0] VAL_ONES = '1;

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    req        <= '0;
    words_sent = 0;
    burst      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Probe into an empty store: no result.
    send_word(REQ_PROBE, 64'd5);
    // Extremes of the value field.
    send_word(REQ_LOAD, VAL_MIN);
    send_word(REQ_LOAD, VAL_MAX);
    send_word(REQ_LOAD, VAL_ZERO);
    send_word(REQ_LOAD, VAL_ONES);
    send_word(REQ_PROBE, VAL_MAX);
    send_word(REQ_PROBE, VAL_MIN);
    send_word(REQ_PROBE, VAL_ZERO);
    send_word(REQ_PROBE, VAL_ONES);
    // Miss: no result, total unchanged.
    send_word(REQ_PROBE, 64'd1);
    // Repeated probe value is reported again.
    send_word(REQ_PROBE, VAL_MAX);
    // Unused request code: ignored.
    send_word(REQ_UNUSED, VAL_MAX);
    // Late load only counts for probes after it.
    send_word(REQ_PROBE, 64'd42);
    send_word(REQ_LOAD, 64'd42);
    send_word(REQ_PROBE, 64'd42);
    // End word ignores its value; second end closes an empty segment.
    send_word(REQ_END, any_value());
    send_word(REQ_END, VAL_ZERO);
    // Store is empty again after the end.
    send_word(REQ_PROBE, VAL_ZERO);
    // Same value stored twice still yields one match per probe.
    send_word(REQ_LOAD, 64'd7);
    send_word(REQ_LOAD, 64'd7);
    send_word(REQ_PROBE, 64'd7);
    send_word(REQ_END, VAL_ZERO);
    // Total saturation at its maximum lies billions of matches away and is
    // not reached here; store overflow comes from the long random segments.

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) run_segment();
    send_word(REQ_END, VAL_ZERO);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0)
      $display("segmented_list_intersection verification clean");
    else
      $display("segmented_list_intersection verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/segmented_list_intersection.sv
tb/sv/sli_intersection_checker.sv
tb/sv/tb_segmented_list_intersection.sv
